// File: design/urs_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the unique random sequence generator.
package urs_pkg;

    localparam int unsigned WORD_W = 32;

    // Prime 2^32 - 5 and its floor half
    localparam logic [WORD_W-1:0] QR_PRIME     = 32'hFFFF_FFFB;
    localparam logic [WORD_W-1:0] QR_HALF      = 32'h7FFF_FFFD;

    localparam logic [WORD_W-1:0] SEED_POS_ADD = 32'h682F_0161;
    localparam logic [WORD_W-1:0] SEED_OFF_ADD = 32'h4679_0905;
    localparam logic [WORD_W-1:0] OUT_XOR      = 32'h5BF0_3635;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_OFFSET = 1'b1;

    // Sequencer to permutation unit
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] operand;
    } qr_req_t;

    // Permutation unit to sequencer
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] result;
    } qr_rsp_t;

endpackage

// File: design/urs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and value items.

interface urs_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface urs_out_if;
    logic                       valid;
    logic                       ready;
    logic [urs_pkg::WORD_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// File: design/urs_qr_unit.sv
`timescale 1ns / 1ps
// Shared quadratic-residue permutation unit: square, two folds, final reduce.
module urs_qr_unit
(
    input  logic             clk,
    input  logic             rst_n,
    input  urs_pkg::qr_req_t req,
    output urs_pkg::qr_rsp_t rsp
);

    typedef enum logic [4:0] {
        Q_IDLE  = 5'b00001,
        Q_MUL   = 5'b00010,
        Q_FOLD1 = 5'b00100,
        Q_FOLD2 = 5'b01000,
        Q_FIN   = 5'b10000
    } qr_state_t;

    qr_state_t   state_reg, state_next;
    logic [31:0] x_reg;
    logic [63:0] prod_reg;
    logic [34:0] fold1_reg, fold1_next;
    logic [32:0] fold2_reg, fold2_next;
    logic [31:0] result_reg, result_next;
    logic        done_reg;
    logic [31:0] reduced;

    // 2^32 == 5 (mod p): fold the high word back in twice
    assign fold1_next = {1'b0, prod_reg[63:32], 2'b00} + {3'b000, prod_reg[63:32]}
                      + {3'b000, prod_reg[31:0]};
    assign fold2_next = {28'd0, fold1_reg[34:32], 2'b00} + {30'd0, fold1_reg[34:32]}
                      + {1'b0, fold1_reg[31:0]};

    // fold2 < 2p, one subtract finishes the reduction
    assign reduced = (fold2_reg >= {1'b0, urs_pkg::QR_PRIME})
                   ? 32'(fold2_reg - {1'b0, urs_pkg::QR_PRIME}) : fold2_reg[31:0];

    always_comb
    begin
        if (x_reg >= urs_pkg::QR_PRIME)
        begin
            result_next = x_reg;
        end
        else if (x_reg <= urs_pkg::QR_HALF)
        begin
            result_next = reduced;
        end
        else
        begin
            result_next = urs_pkg::QR_PRIME - reduced;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            Q_IDLE:  if (req.start) state_next = Q_MUL;
            Q_MUL:   state_next = Q_FOLD1;
            Q_FOLD1: state_next = Q_FOLD2;
            Q_FOLD2: state_next = Q_FIN;
            Q_FIN:   state_next = Q_IDLE;
            default: state_next = Q_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == Q_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == Q_IDLE && req.start)
        begin
            x_reg <= req.operand;
        end
        if (state_reg == Q_MUL)
        begin
            prod_reg <= x_reg * x_reg;
        end
        if (state_reg == Q_FOLD1)
        begin
            fold1_reg <= fold1_next;
        end
        if (state_reg == Q_FOLD2)
        begin
            fold2_reg <= fold2_next;
        end
        if (state_reg == Q_FIN)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp.busy   = (state_reg != Q_IDLE);
    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

// File: design/unique_random_sequence_generator_unit.sv
`timescale 1ns / 1ps
// Top level of the unique random sequence generator.
//
// Each request item on in_ch yields one 32-bit value item on out_ch; over 2^32
// requests the values never repeat. The core is the permutation Q(x) = x*x mod p
// (or p minus that for x above p/2, and x itself for x >= p), p = 2^32 - 5.
// A value is Q((Q(position) + mix_offset) ^ 0x5bf03635), after which position
// steps by one with wrap. On the first request after reset, or any request with
// restart set, position and mix_offset are first rederived from the seed_base and
// seed_offset registers, which costs four more permutations. All permutations
// run one after another through a single shared unit (one 32x32 multiplier,
// two modular folds, a final reduce). in_ch.ready is low while an item is in
// work; a finished value sits in an output register, so a new request is
// taken while it waits for out_ch.ready. Seed writes take effect at the next
// reseed.
module unique_random_sequence_generator_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [urs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [urs_pkg::WORD_W-1:0]    cfg_wdata,
    urs_in_if.sink                        in_ch,
    urs_out_if.source                     out_ch
);

    // Sequencer steps: SB/SO derive position/offset, POS and OUT make the value
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SB1  = 8'b0000_0010,
        S_SB2  = 8'b0000_0100,
        S_SO1  = 8'b0000_1000,
        S_SO2  = 8'b0001_0000,
        S_POS  = 8'b0010_0000,
        S_OUT  = 8'b0100_0000,
        S_HOLD = 8'b1000_0000
    } seq_state_t;

    seq_state_t                 state_reg, state_next;
    logic [urs_pkg::WORD_W-1:0] seed_base_reg;
    logic [urs_pkg::WORD_W-1:0] seed_offset_reg;
    logic [urs_pkg::WORD_W-1:0] position_reg, position_next;
    logic [urs_pkg::WORD_W-1:0] mix_reg, mix_next;
    logic                       seeded_reg, seeded_next;
    logic                       out_valid_reg, out_valid_next;
    logic [urs_pkg::WORD_W-1:0] value_reg;

    urs_pkg::qr_req_t           qr_req;
    urs_pkg::qr_rsp_t           qr_rsp;

    logic                       accept;
    logic                       out_free;
    logic                       load_out;

    urs_qr_unit u_qr
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (qr_req),
        .rsp   (qr_rsp)
    );

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.value = value_reg;

    // Steps SB1 to POS launch the next permutation in the cycle the previous one is done
    always_comb
    begin
        state_next     = state_reg;
        position_next  = position_reg;
        mix_next       = mix_reg;
        seeded_next    = seeded_reg;
        load_out       = 1'b0;
        qr_req.start   = 1'b0;
        qr_req.operand = position_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    qr_req.start = 1'b1;
                    if (!seeded_reg || in_ch.restart)
                    begin
                        qr_req.operand = seed_base_reg;
                        seeded_next    = 1'b1;
                        state_next     = S_SB1;
                    end
                    else
                    begin
                        qr_req.operand = position_reg;
                        state_next     = S_POS;
                    end
                end
            end
            S_SB1:
            begin
                if (qr_rsp.done)
                begin
                    qr_req.start   = 1'b1;
                    qr_req.operand = qr_rsp.result + urs_pkg::SEED_POS_ADD;
                    state_next     = S_SB2;
                end
            end
            S_SB2:
            begin
                if (qr_rsp.done)
                begin
                    position_next  = qr_rsp.result;
                    qr_req.start   = 1'b1;
                    qr_req.operand = seed_offset_reg;
                    state_next     = S_SO1;
                end
            end
            S_SO1:
            begin
                if (qr_rsp.done)
                begin
                    qr_req.start   = 1'b1;
                    qr_req.operand = qr_rsp.result + urs_pkg::SEED_OFF_ADD;
                    state_next     = S_SO2;
                end
            end
            S_SO2:
            begin
                if (qr_rsp.done)
                begin
                    mix_next       = qr_rsp.result;
                    qr_req.start   = 1'b1;
                    qr_req.operand = position_reg;
                    state_next     = S_POS;
                end
            end
            S_POS:
            begin
                if (qr_rsp.done)
                begin
                    qr_req.start   = 1'b1;
                    qr_req.operand = (qr_rsp.result + mix_reg) ^ urs_pkg::OUT_XOR;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (qr_rsp.done)
                begin
                    position_next = position_reg + 32'd1;
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                // unit result stays put until the next start
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            seed_base_reg   <= '0;
            seed_offset_reg <= '0;
            position_reg    <= '0;
            mix_reg         <= '0;
            seeded_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            position_reg  <= position_next;
            mix_reg       <= mix_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    urs_pkg::CFG_SEED_BASE:   seed_base_reg   <= cfg_wdata;
                    urs_pkg::CFG_SEED_OFFSET: seed_offset_reg <= cfg_wdata;
                    default:                  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            value_reg <= qr_rsp.result;
        end
    end

    // The shared unit is only started when it is free
    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        qr_req.start |-> !qr_rsp.busy)
        else $error("permutation unit started while busy");

    // A value appears only at the end of the final permutation
    a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT || state_reg == S_HOLD))
        else $error("output valid without a finished value");

    // Once seeded, stays seeded until reset
    a_seeded_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        seeded_reg |=> seeded_reg)
        else $error("seeded flag dropped");

    // Unit completions only arrive while an item is in work
    a_done_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        qr_rsp.done |-> (state_reg != S_IDLE && state_reg != S_HOLD))
        else $error("permutation done with no item in work");

endmodule

// File: tb/unique_random_sequence_generator_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for the unique random sequence generator: directed table, random phases, scoreboard.
module unique_random_sequence_generator_unit_tb;

    // Constants of the square permutation, kept apart from the package so the
    // prediction does not lean on the design's own numbers.
    localparam logic [31:0] PRIME      = 32'hFFFF_FFFB;  // 2^32 - 5
    localparam logic [31:0] HALF_PRIME = 32'h7FFF_FFFD;
    localparam logic [31:0] POS_SALT   = 32'h682F_0161;
    localparam logic [31:0] OFF_SALT   = 32'h4679_0905;
    localparam logic [31:0] OUT_MASK   = 32'h5BF0_3635;
    // (p + 1) / 4: square root exponent, valid because p = 3 mod 4
    localparam logic [31:0] ROOT_EXP   = 32'h3FFF_FFFF;

    localparam int NUM_DIRECTED    = 18;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 75;
    // A quiet stretch of WATCHDOG_LIMIT means a hang,
    // even with the sender or receiver idling 64 percent of the time.
    localparam int WATCHDOG_LIMIT  = 2000;
    // Covers the longest request latency before the final verdict.
    localparam int SETTLE_CYCLES   = 40;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [urs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [urs_pkg::WORD_W-1:0] cfg_wdata;

    urs_in_if  in_ch();
    urs_out_if out_ch();

    unique_random_sequence_generator_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state: a shadow of the seed registers and of the sequencer.
    logic [31:0] shadow_seed_base   = '0;
    logic [31:0] shadow_seed_offset = '0;
    logic [31:0] seq_position       = '0;
    logic [31:0] seq_mix            = '0;
    logic        seq_seeded         = 1'b0;

    // Values predicted at request acceptance, oldest first.
    logic [31:0] pending_values [$];
    int mismatches    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // Directed row: optional seed writes (done while idle), then one request.
    typedef struct packed {
        logic        wr_base;
        logic [31:0] base;
        logic        wr_off;
        logic [31:0] off;
        logic        restart;
    } stim_row_t;

    // Every value goes through two squarings mod p, so no row carries a
    // hand-typed value; all rows are checked against the predictor.
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        // first request after reset seeds from the zero registers
        '{1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
        // restart with the same seeds replays the first value
        '{1'b0, 32'h0, 1'b0, 32'h0, 1'b1},
        // seed write after seeding stays dormant until a restart
        '{1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{1'b0, 32'h0, 1'b0, 32'h0, 1'b1},
        '{1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
        // seeds at or above the prime are fixed points
        '{1'b1, 32'hFFFF_FFFB, 1'b1, 32'hFFFF_FFFD, 1'b1},
        // seeds at and just past the half-prime fold
        '{1'b1, 32'h7FFF_FFFD, 1'b1, 32'h7FFF_FFFE, 1'b1},
        // seeds filled in at run time: position lands on 0xFFFFFFFA and the
        // final permutation input lands above the prime
        '{1'b1, 32'h0, 1'b1, 32'h0, 1'b1},
        // walk position through the values above the prime and the wrap to 0
        '{1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
        // back to zero seeds, dormant first, then live
        '{1'b1, 32'h0, 1'b1, 32'h0, 1'b0},
        '{1'b0, 32'h0, 1'b0, 32'h0, 1'b1}
    };

    // Q(x): x*x mod p, folded to p minus that above p/2, identity at x >= p.
    function automatic logic [31:0] qr_permute(input logic [31:0] x);
        logic [63:0] sq;
        logic [31:0] r;
        if (x >= PRIME)
            return x;
        sq = {32'b0, x} * {32'b0, x};
        r  = 32'(sq % {32'b0, PRIME});
        return (x <= HALF_PRIME) ? r : PRIME - r;
    endfunction

    function automatic logic [31:0] mod_pow(input logic [31:0] b, input logic [31:0] e);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [31:0] k;
        acc = 64'd1;
        sq  = {32'b0, b} % {32'b0, PRIME};
        k   = e;
        while (k != 0)
        begin
            if (k[0])
                acc = (acc * sq) % {32'b0, PRIME};
            sq = (sq * sq) % {32'b0, PRIME};
            k  = k >> 1;
        end
        return acc[31:0];
    endfunction

    // Inverse of Q, used to aim seeds at chosen positions. Residues come from
    // the lower half, non-residues from p minus a root in the upper half.
    function automatic logic [31:0] qr_invert(input logic [31:0] y);
        logic [31:0] r;
        logic [63:0] chk;
        if (y >= PRIME)
            return y;
        r   = mod_pow(y, ROOT_EXP);
        chk = ({32'b0, r} * {32'b0, r}) % {32'b0, PRIME};
        if (chk[31:0] == y)
            return (r <= HALF_PRIME) ? r : PRIME - r;
        r = mod_pow(PRIME - y, ROOT_EXP);
        return (r > HALF_PRIME) ? r : PRIME - r;
    endfunction

    // Next value of the sequence; reseeds on the first request or on restart.
    function automatic logic [31:0] predict_value(input logic restart_bit);
        logic [31:0] t;
        if (!seq_seeded || restart_bit)
        begin
            t            = qr_permute(shadow_seed_base) + POS_SALT;
            seq_position = qr_permute(t);
            t            = qr_permute(shadow_seed_offset) + OFF_SALT;
            seq_mix      = qr_permute(t);
            seq_seeded   = 1'b1;
        end
        t = qr_permute(seq_position) + seq_mix;
        t = t ^ OUT_MASK;
        seq_position = seq_position + 32'd1;
        return qr_permute(t);
    endfunction

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return PRIME + $urandom_range(0, 4);
            3: return HALF_PRIME - 32'd1 + $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    // Offer one request, idling first at the current rate; valid drops on the
    // edge after acceptance, while the block is still busy with the item.
    task automatic send_request(input logic restart_bit);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.restart <= restart_bit;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_values.push_back(predict_value(restart_bit));
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // One result per request, so an empty queue means the block is idle.
    task automatic drain_values();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_values.size() != 0)
            @(posedge clk);
    endtask

    // Seed writes, back to back; the write enable drops once at the end.
    task automatic program_seeds(input logic wr_base, input logic [31:0] base,
                                 input logic wr_off, input logic [31:0] off);
        if (wr_base)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= urs_pkg::CFG_SEED_BASE;
            cfg_wdata <= base;
            shadow_seed_base = base;
            @(posedge clk);
        end
        if (wr_off)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= urs_pkg::CFG_SEED_OFFSET;
            cfg_wdata <= off;
            shadow_seed_offset = off;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Output side: score each accepted value, then pick next cycle's ready.
    initial
    begin
        logic [31:0] want;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (pending_values.size() == 0)
                begin
                    $display("%0t: unexpected value, expected none, got %h",
                             $time, out_ch.value);
                    mismatches++;
                end
                else
                begin
                    want = pending_values.pop_front();
                    if (out_ch.value !== want)
                    begin
                        $display("%0t: value mismatch, expected %h, got %h",
                                 $time, want, out_ch.value);
                        mismatches++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: any accepted item on either channel resets the count.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: watchdog expired with %0d values outstanding",
                 $time, pending_values.size());
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus: reset, directed table, then random phases over the idle modes.
    initial
    begin
        stim_row_t   row;
        logic [31:0] wrap_mix;
        logic        wr_b;
        logic        wr_o;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= urs_pkg::CFG_SEED_BASE;
        cfg_wdata     <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.restart <= 1'b0;

        // Aim the run-time row: position 0xFFFFFFFA first, and a mix offset
        // that pushes the last permutation's input to 0xFFFFFFFD.
        directed_rows[8].base = qr_invert(qr_invert(32'hFFFF_FFFA) - POS_SALT);
        wrap_mix = ((PRIME + 32'd2) ^ OUT_MASK) - qr_permute(32'hFFFF_FFFA);
        directed_rows[8].off  = qr_invert(qr_invert(wrap_mix) - OFF_SALT);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            row = directed_rows[i];
            if (row.wr_base || row.wr_off)
            begin
                drain_values();
                program_seeds(row.wr_base, row.base, row.wr_off, row.off);
            end
            send_request(row.restart);
        end

        // Phase modes: no idling, sender idle, receiver stalling, both.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_values();
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 64; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            wr_b = ($urandom_range(0, 3) != 0);
            wr_o = ($urandom_range(0, 3) != 0);
            if (wr_b || wr_o)
                program_seeds(wr_b, pick_seed(), wr_o, pick_seed());
            // mostly pick up the fresh seeds at once; sometimes leave them dormant
            send_request($urandom_range(0, 3) != 0);
            for (int n = 1; n < ITEMS_PER_PHASE; n++)
                send_request($urandom_range(0, 7) == 0);
        end

        drain_values();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_values.size() != 0)
        begin
            $display("%0t: %0d expected values never arrived", $time,
                     pending_values.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: unique_random_sequence_generator_unit.f
design/urs_pkg.sv
design/urs_if.sv
design/urs_qr_unit.sv
design/unique_random_sequence_generator_unit.sv
tb/unique_random_sequence_generator_unit_tb.sv
